[hw/rtl/irpm_pkg.sv]
// irpm_pkg: shared types, constants and reset values of the irprop- weight update unit
// no dependencies; imported by irpm_cfg, irpm_front, irpm_back and the top level
package irpm_pkg;

  // fixed point and field widths
  localparam int FRAC_BITS   = 20;
  localparam int ENTRIES     = 4096;
  localparam int IDX_W       = $clog2(ENTRIES);
  localparam int GRAD_W      = 32;
  localparam int WEIGHT_W    = 32;
  localparam int STEP_W      = 31;
  localparam int FAC_W       = 16;
  localparam int FAC_FRAC    = 14;
  localparam int PROD_W      = STEP_W + FAC_W;
  localparam int SCALED_W    = PROD_W + 1 - FAC_FRAC;
  localparam int WSUM_W      = WEIGHT_W + 2;
  localparam int ENTRY_W     = GRAD_W + STEP_W;

  // stream packing
  localparam int IN_DATA_W   = 80;
  localparam int OUT_DATA_W  = 80;

  // apb register file
  localparam int CFG_ADDR_W  = 5;
  localparam int CFG_DATA_W  = 32;

  // front queue
  localparam int Q_DEPTH     = 2;
  localparam int Q_PTR_W     = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

  localparam logic [STEP_W-1:0]   STEP_MAX   = {STEP_W{1'b1}};
  localparam logic [PROD_W:0]     ROUND_HALF = (PROD_W + 1)'(1) << (FAC_FRAC - 1);
  localparam logic [WEIGHT_W-1:0] W_MAX      = {1'b0, {(WEIGHT_W-1){1'b1}}};
  localparam logic [WEIGHT_W-1:0] W_MIN      = {1'b1, {(WEIGHT_W-1){1'b0}}};

  // saturate an elaboration-time value to the step range
  function automatic logic [STEP_W-1:0] clamp_const(input longint unsigned v);
    clamp_const = (v > longint'(STEP_MAX)) ? STEP_MAX : STEP_W'(v);
  endfunction

  localparam longint unsigned ONE_FIX = longint'(1) << FRAC_BITS;
  localparam logic [FAC_W-1:0]  GROW_RST   = 16'd19661;
  localparam logic [FAC_W-1:0]  SHRINK_RST = 16'd8192;
  localparam logic [STEP_W-1:0] CEIL_RST   = clamp_const(ONE_FIX * 50);
  localparam logic [STEP_W-1:0] START_RST  = clamp_const((ONE_FIX * 15 + 500) / 1000);
  localparam logic [STEP_W-1:0] FLOOR_CALC = clamp_const((ONE_FIX + 500000) / 1000000);
  localparam logic [STEP_W-1:0] FLOOR_RST  = (FLOOR_CALC == '0) ? STEP_W'(1) : FLOOR_CALC;

  // item kind on in_tuser
  typedef enum logic {
    KIND_INIT   = 1'b0,
    KIND_UPDATE = 1'b1
  } kind_t;

  // sign case on out_tuser
  typedef enum logic [1:0] {
    CASE_SAME = 2'd0,
    CASE_REV  = 2'd1,
    CASE_ZERO = 2'd2,
    CASE_INIT = 2'd3
  } case_t;

  // classified item between front and back
  typedef struct packed {
    kind_t                kind;
    logic [IDX_W-1:0]     idx;
    logic [GRAD_W-1:0]    grad;
    logic [WEIGHT_W-1:0]  weight;
    logic                 g_pos;
    logic                 g_neg;
  } irpm_item_t;

  // configuration registers as seen by the back end
  typedef struct packed {
    logic [FAC_W-1:0]  grow;
    logic [FAC_W-1:0]  shrink;
    logic [STEP_W-1:0] ceiling;
    logic [STEP_W-1:0] floor_lim;
    logic [STEP_W-1:0] start;
  } irpm_cfg_t;

endpackage

[hw/rtl/irpm_ram.sv]
// irpm_ram: generic single-write, single-read ram with registered read data
// no dependencies
module irpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port, read port returns old data on collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/irpm_cfg.sv]
// irpm_cfg: apb register file for growth, shrink and step limit registers
// depends on irpm_pkg
module irpm_cfg
  import irpm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready,
  output irpm_cfg_t             cfg
);

  typedef enum logic [2:0] {
    REG_GROW   = 3'd0,
    REG_SHRINK = 3'd1,
    REG_CEIL   = 3'd2,
    REG_FLOOR  = 3'd3,
    REG_START  = 3'd4
  } reg_idx_t;

  logic [FAC_W-1:0]  grow_r, shrink_r;
  logic [STEP_W-1:0] ceil_r, floor_r, start_r;
  logic [2:0]        reg_sel;
  logic              wr_en;

  assign cfg_pready = 1'b1;
  assign reg_sel    = cfg_paddr[4:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grow_r   <= GROW_RST;
      shrink_r <= SHRINK_RST;
      ceil_r   <= CEIL_RST;
      floor_r  <= FLOOR_RST;
      start_r  <= START_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_GROW:   grow_r   <= cfg_pwdata[FAC_W-1:0];
        REG_SHRINK: shrink_r <= cfg_pwdata[FAC_W-1:0];
        REG_CEIL:   ceil_r   <= cfg_pwdata[STEP_W-1:0];
        REG_FLOOR:  floor_r  <= cfg_pwdata[STEP_W-1:0];
        REG_START:  start_r  <= cfg_pwdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (reg_sel)
      REG_GROW:   cfg_prdata = CFG_DATA_W'(grow_r);
      REG_SHRINK: cfg_prdata = CFG_DATA_W'(shrink_r);
      REG_CEIL:   cfg_prdata = CFG_DATA_W'(ceil_r);
      REG_FLOOR:  cfg_prdata = CFG_DATA_W'(floor_r);
      REG_START:  cfg_prdata = CFG_DATA_W'(start_r);
      default:    cfg_prdata = '0;
    endcase
  end

  assign cfg.grow      = grow_r;
  assign cfg.shrink    = shrink_r;
  assign cfg.ceiling   = ceil_r;
  assign cfg.floor_lim = floor_r;
  assign cfg.start     = start_r;

endmodule

[hw/rtl/irpm_front.sv]
// irpm_front: accepts input items, classifies the gradient sign, queues them
// depends on irpm_pkg
module irpm_front
  import irpm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,
  input  logic                 in_tuser,
  output logic                 q_valid,
  output irpm_item_t           q_item,
  input  logic                 q_pop
);

  irpm_item_t         q_mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0] count_r;
  irpm_item_t         new_item;
  logic               push;

  // unpack and classify the incoming item
  always_comb begin
    new_item.kind   = kind_t'(in_tuser);
    new_item.idx    = in_tdata[IDX_W-1:0];
    new_item.grad   = in_tdata[12 +: GRAD_W];
    new_item.weight = in_tdata[44 +: WEIGHT_W];
    new_item.g_neg  = new_item.grad[GRAD_W-1];
    new_item.g_pos  = !new_item.grad[GRAD_W-1] && (new_item.grad != '0);
  end

  assign in_tready = (count_r != Q_CNT_W'(Q_DEPTH));
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (count_r != '0);
  assign q_item    = q_mem_r[rd_ptr_r];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= new_item;
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !q_pop) begin
        count_r <= count_r + 1'b1;
      end else if (!push && q_pop) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // a pushed item is visible to the back end next cycle
  a_push_visible: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !q_pop) |=> q_valid)
    else $error("queue lost a pushed item");

  // pop never happens on an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (count_r != '0))
    else $error("queue popped while empty");

endmodule

[hw/rtl/irpm_back.sv]
// irpm_back: entry read-modify-write, step scaling, weight update, output register
// depends on irpm_pkg and irpm_ram
module irpm_back
  import irpm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  irpm_cfg_t             cfg,
  input  logic                  q_valid,
  input  irpm_item_t            q_item,
  output logic                  q_pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [1:0]            out_tuser
);

  // execute stage
  logic               e_valid_r;
  irpm_item_t         e_item_r;
  logic               e_fire;

  // last written entry, forwarded to the next read of the same index
  logic               lw_valid_r;
  logic [IDX_W-1:0]   lw_idx_r;
  logic [GRAD_W-1:0]  lw_grad_r;
  logic [STEP_W-1:0]  lw_step_r;

  // output register
  logic                out_valid_r;
  logic [IDX_W-1:0]    out_idx_r;
  logic [WEIGHT_W-1:0] out_weight_r;
  logic [STEP_W-1:0]   out_step_r;
  case_t               out_case_r;

  logic [ENTRY_W-1:0]  rd_data;
  logic [ENTRY_W-1:0]  wr_data;
  logic [GRAD_W-1:0]   prev;
  logic [STEP_W-1:0]   cur_step;
  logic                p_pos, p_neg, same, rev;
  logic [FAC_W-1:0]    factor;
  logic [PROD_W-1:0]   prod;
  logic [PROD_W:0]     rounded;
  logic [SCALED_W-1:0] scaled;
  logic [STEP_W-1:0]   scaled_sat;
  logic [STEP_W-1:0]   new_step;
  logic [GRAD_W-1:0]   new_grad;
  logic [WSUM_W-1:0]   w_ext, s_ext, w_sum;
  logic [WEIGHT_W-1:0] w_sat, new_weight;
  case_t               new_case;

  assign e_fire = e_valid_r && (!out_valid_r || out_tready);
  assign q_pop  = q_valid && (!e_valid_r || e_fire);

  irpm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (e_fire),
    .waddr (e_item_r.idx),
    .wdata (wr_data),
    .re    (q_pop),
    .raddr (q_item.idx),
    .rdata (rd_data)
  );

  // stored entry, with forwarding of the most recent write
  always_comb begin
    if (lw_valid_r && (lw_idx_r == e_item_r.idx)) begin
      prev     = lw_grad_r;
      cur_step = lw_step_r;
    end else begin
      prev     = rd_data[STEP_W +: GRAD_W];
      cur_step = rd_data[STEP_W-1:0];
    end
  end

  // sign classification
  assign p_neg = prev[GRAD_W-1];
  assign p_pos = !prev[GRAD_W-1] && (prev != '0);
  assign same  = (e_item_r.g_pos && p_pos) || (e_item_r.g_neg && p_neg);
  assign rev   = (e_item_r.g_pos || e_item_r.g_neg) && (p_pos || p_neg) && !same;

  // step scaling with round half up, saturated to the step range
  assign factor     = same ? cfg.grow : cfg.shrink;
  assign prod       = PROD_W'(cur_step) * PROD_W'(factor);
  assign rounded    = (PROD_W + 1)'(prod) + ROUND_HALF;
  assign scaled     = rounded[PROD_W:FAC_FRAC];
  assign scaled_sat = (scaled[SCALED_W-1:STEP_W] != '0) ? STEP_MAX : scaled[STEP_W-1:0];

  // new step, stored gradient and sign case
  always_comb begin
    if (e_item_r.kind == KIND_INIT) begin
      new_step = cfg.start;
      new_grad = '0;
      new_case = CASE_INIT;
    end else if (same) begin
      new_step = (scaled_sat > cfg.ceiling) ? cfg.ceiling : scaled_sat;
      new_grad = e_item_r.grad;
      new_case = CASE_SAME;
    end else if (rev) begin
      new_step = (scaled_sat < cfg.floor_lim) ? cfg.floor_lim : scaled_sat;
      new_grad = '0;
      new_case = CASE_REV;
    end else begin
      new_step = cur_step;
      new_grad = e_item_r.grad;
      new_case = CASE_ZERO;
    end
  end

  // weight moves against the gradient sign, saturated to 32 bits
  assign w_ext = {{(WSUM_W - WEIGHT_W){e_item_r.weight[WEIGHT_W-1]}}, e_item_r.weight};
  assign s_ext = WSUM_W'(new_step);
  always_comb begin
    if (e_item_r.g_pos) begin
      w_sum = w_ext - s_ext;
    end else if (e_item_r.g_neg) begin
      w_sum = w_ext + s_ext;
    end else begin
      w_sum = w_ext;
    end
    if ((w_sum[WSUM_W-1:WEIGHT_W-1] == '0) || (w_sum[WSUM_W-1:WEIGHT_W-1] == '1)) begin
      w_sat = w_sum[WEIGHT_W-1:0];
    end else if (w_sum[WSUM_W-1]) begin
      w_sat = W_MIN;
    end else begin
      w_sat = W_MAX;
    end
  end

  assign new_weight = (new_case == CASE_SAME || new_case == CASE_ZERO) ? w_sat
                                                                       : e_item_r.weight;
  assign wr_data    = {new_grad, new_step};

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_valid_r   <= 1'b0;
      lw_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        e_valid_r <= 1'b1;
      end else if (e_fire) begin
        e_valid_r <= 1'b0;
      end
      if (e_fire) begin
        lw_valid_r  <= 1'b1;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      e_item_r <= q_item;
    end
    if (e_fire) begin
      lw_idx_r     <= e_item_r.idx;
      lw_grad_r    <= new_grad;
      lw_step_r    <= new_step;
      out_idx_r    <= e_item_r.idx;
      out_weight_r <= new_weight;
      out_step_r   <= new_step;
      out_case_r   <= new_case;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'({out_step_r, out_weight_r, out_idx_r});
  assign out_tuser  = out_case_r;

  // a stalled execute item keeps its place and index
  a_e_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (e_valid_r && !e_fire) |=> (e_valid_r && $stable(e_item_r.idx)))
    else $error("execute stage dropped a stalled item");

  // forwarding register tracks the entry just written
  a_lw_track: assert property (@(posedge clk) disable iff (!rst_n)
    e_fire |=> (lw_valid_r && (lw_idx_r == $past(e_item_r.idx))))
    else $error("forwarding register out of step with writes");

  // a new result appears only from an executed item
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(e_fire))
    else $error("result without an executed item");

endmodule

[hw/rtl/irprop_minus_weight_update_unit.sv]
// irprop_minus_weight_update_unit: top level of the irprop- per-weight update engine
// depends on irpm_pkg, irpm_cfg, irpm_front, irpm_back (and irpm_ram below it)
//
//  channel | direction | handshake              | payload
//  in_     | slave     | in_tvalid / in_tready   | tdata index, gradient, weight; tuser kind
//  out_    | master    | out_tvalid / out_tready | tdata index, weight, step; tuser sign case
//  cfg_    | apb slave | psel, penable, pready   | 5 registers at byte address 4*i
//
// one item per cycle sustained while out_tready stays high; an item is accepted into a
// two-entry queue, read from the entry ram into the execute stage when popped, then
// executed and registered at the output. the rate is set by the read-modify-write of the
// execute stage, with the last write forwarded to a following item on the same index.
// synchronous active-low reset clears control and configuration registers only; entry memory is not cleared.
// an output stall holds the output register, then the execute stage, then the queue.
module irprop_minus_weight_update_unit
  import irpm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input items
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // weight_index[11:0], gradient[43:12], weight_in[75:44]
  input  logic                  in_tuser,   // kind
  // result items
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // index_out[11:0], weight_out[43:12], step_out[74:44]
  output logic [1:0]            out_tuser,  // sign_case
  // configuration
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  irpm_cfg_t  cfg;
  irpm_item_t q_item;
  logic       q_valid;
  logic       q_pop;

  // register file
  irpm_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // accept, classify and queue
  irpm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  // execute and deliver
  irpm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
